// ===== hdl/msrs_pkg.sv =====
// ----------------------------------------------------------------------------
// msrs_pkg
// Shared types and constants of the multi-channel sonar ranging sequencer:
// opcodes, channel mode encoding, register map and the inter-stage records.
// ----------------------------------------------------------------------------
`default_nettype none

package msrs_pkg;

   // transaction opcodes
   localparam logic [2:0] OP_POLL  = 3'd0;
   localparam logic [2:0] OP_RISE  = 3'd1;
   localparam logic [2:0] OP_FALL  = 3'd2;
   localparam logic [2:0] OP_START = 3'd3;
   localparam logic [2:0] OP_STOP  = 3'd4;

   // reported sensor state codes
   localparam logic [2:0] SC_IDLE = 3'd0;
   localparam logic [2:0] SC_TRIG = 3'd1;
   localparam logic [2:0] SC_WAIT = 3'd2;
   localparam logic [2:0] SC_ECHO = 3'd3;
   localparam logic [2:0] SC_STOP = 3'd4;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_SILENCE_GAP  = 3'd0;
   localparam logic [2:0] REG_TRIG_PULSE   = 3'd1;
   localparam logic [2:0] REG_WAIT_TIMEOUT = 3'd2;
   localparam logic [2:0] REG_ECHO_MAX     = 3'd3;
   localparam logic [2:0] REG_SCALE        = 3'd4;

   localparam logic [19:0] RST_SILENCE_GAP  = 20'd10000;
   localparam logic [9:0]  RST_TRIG_PULSE   = 10'd10;
   localparam logic [19:0] RST_WAIT_TIMEOUT = 20'd20000;
   localparam logic [19:0] RST_ECHO_MAX     = 20'd30000;
   localparam logic [15:0] RST_SCALE        = 16'd11239;

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_TRIG = 5'b00010,
      MODE_WAIT = 5'b00100,
      MODE_ECHO = 5'b01000,
      MODE_STOP = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [19:0] silence_gap_us;
      logic [9:0]  trigger_pulse_us;
      logic [19:0] echo_wait_timeout_us;
      logic [19:0] echo_max_us;
      logic [15:0] mm_per_us_q16;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  channel;
      logic [31:0] now_us;
   } req_type;

   typedef struct packed {
      logic [3:0]  active_channel;
      logic        trigger_level;
      logic [2:0]  sensor_state;
      logic        distance_valid;
      logic [31:0] echo_width_us;
      logic [31:0] frame_count;
   } stage_type;

   typedef struct packed {
      logic [3:0]  active_channel;
      logic        trigger_level;
      logic [2:0]  sensor_state;
      logic        distance_valid;
      logic [31:0] echo_width_us;
      logic [15:0] distance_mm;
      logic [31:0] frame_count;
   } rsp_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] code;
      case (m)
         MODE_IDLE: code = SC_IDLE;
         MODE_TRIG: code = SC_TRIG;
         MODE_WAIT: code = SC_WAIT;
         MODE_ECHO: code = SC_ECHO;
         MODE_STOP: code = SC_STOP;
         default:   code = SC_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/msrs_csr.sv =====
// ----------------------------------------------------------------------------
// msrs_csr
// APB-style configuration registers: timing thresholds and distance scale.
// ----------------------------------------------------------------------------
`default_nettype none

module msrs_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           psel,
   input  wire logic           penable,
   input  wire logic           pwrite,
   input  wire logic [4:0]     paddr,
   input  wire logic [31:0]    pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output msrs_pkg::cfg_type   cfg
);
   import msrs_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel & penable & pwrite & pready;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.silence_gap_us       <= RST_SILENCE_GAP;
         cfg_ff.trigger_pulse_us     <= RST_TRIG_PULSE;
         cfg_ff.echo_wait_timeout_us <= RST_WAIT_TIMEOUT;
         cfg_ff.echo_max_us          <= RST_ECHO_MAX;
         cfg_ff.mm_per_us_q16        <= RST_SCALE;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SILENCE_GAP:  cfg_ff.silence_gap_us       <= pwdata[19:0];
            REG_TRIG_PULSE:   cfg_ff.trigger_pulse_us     <= pwdata[9:0];
            REG_WAIT_TIMEOUT: cfg_ff.echo_wait_timeout_us <= pwdata[19:0];
            REG_ECHO_MAX:     cfg_ff.echo_max_us          <= pwdata[19:0];
            REG_SCALE:        cfg_ff.mm_per_us_q16        <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SILENCE_GAP:  prdata = {12'd0, cfg_ff.silence_gap_us};
         REG_TRIG_PULSE:   prdata = {22'd0, cfg_ff.trigger_pulse_us};
         REG_WAIT_TIMEOUT: prdata = {12'd0, cfg_ff.echo_wait_timeout_us};
         REG_ECHO_MAX:     prdata = {12'd0, cfg_ff.echo_max_us};
         REG_SCALE:        prdata = {16'd0, cfg_ff.mm_per_us_q16};
         default:          prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/msrs_core.sv =====
// ----------------------------------------------------------------------------
// msrs_core
// Per-channel ranging machines, round-robin pointer and slot timer. Each
// channel is a lane that evaluates its own timeouts; the addressed lane is
// updated and its status is captured in the stage register.
// ----------------------------------------------------------------------------
`default_nettype none

module msrs_core #(
   parameter int CHANNELS = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            take,
   input  msrs_pkg::cfg_type    cfg,
   input  msrs_pkg::req_type    item,
   output msrs_pkg::stage_type  result
);
   import msrs_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   mode_type    mode_ff        [CHANNELS];
   mode_type    mode_in        [CHANNELS];
   logic [31:0] trig_start_ff  [CHANNELS];
   logic [31:0] trig_start_in  [CHANNELS];
   logic [31:0] trig_end_ff    [CHANNELS];
   logic [31:0] trig_end_in    [CHANNELS];
   logic [31:0] echo_start_ff  [CHANNELS];
   logic [31:0] echo_start_in  [CHANNELS];
   logic [31:0] echo_end_ff    [CHANNELS];
   logic [31:0] echo_end_in    [CHANNELS];
   logic [31:0] done_ff        [CHANNELS];
   logic [31:0] done_in        [CHANNELS];
   logic        pin_ff         [CHANNELS];
   logic        pin_in         [CHANNELS];
   logic        idle_now       [CHANNELS];
   logic        gap_ok         [CHANNELS];
   logic        fall_ok        [CHANNELS];
   logic [31:0] width_lane     [CHANNELS];

   logic [CH_W-1:0] ptr_ff, ptr_in, ptr_inc, tgt;
   logic [31:0]     slot_ff, slot_in;
   logic [20:0]     slot_limit;
   logic            is_poll, in_range, advance, slot_expired;
   stage_type       result_ff, result_in;

   assign is_poll  = (item.opcode == OP_POLL);
   assign in_range = ({1'b0, item.channel} < 5'(CHANNELS));
   assign result   = result_ff;

   // pointer advance happens before the pointed channel is stepped
   always_comb begin
      ptr_inc      = (ptr_ff == CH_W'(CHANNELS - 1)) ? '0 : ptr_ff + CH_W'(1);
      slot_limit   = {1'b0, cfg.echo_max_us} + {1'b0, cfg.silence_gap_us};
      slot_expired = (item.now_us - slot_ff) > {11'd0, slot_limit};
      advance      = 1'b0;
      slot_in      = slot_ff;
      if (is_poll) begin
         if (idle_now[ptr_ff]) begin
            advance = gap_ok[ptr_ff];
            slot_in = item.now_us;
         end else if (slot_expired) begin
            advance = 1'b1;
            slot_in = item.now_us;
         end
      end
      ptr_in = advance ? ptr_inc : ptr_ff;
      tgt    = is_poll ? ptr_in : item.channel[CH_W-1:0];
   end

   for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_lane
      logic        hit;
      mode_type    lane_mode;
      logic        lane_pin;
      logic [31:0] lane_trig_start, lane_trig_end, lane_echo_start;
      logic [31:0] lane_echo_end, lane_done;

      assign idle_now[gi]   = (mode_ff[gi] == MODE_IDLE);
      assign fall_ok[gi]    = (mode_ff[gi] == MODE_ECHO);
      assign gap_ok[gi]     = (item.now_us - echo_end_ff[gi]) > {12'd0, cfg.silence_gap_us};
      assign width_lane[gi] = item.now_us - echo_start_ff[gi];

      always_comb begin
         hit             = (tgt == CH_W'(gi)) && (is_poll || in_range);
         lane_mode       = mode_ff[gi];
         lane_pin        = pin_ff[gi];
         lane_trig_start = trig_start_ff[gi];
         lane_trig_end   = trig_end_ff[gi];
         lane_echo_start = echo_start_ff[gi];
         lane_echo_end   = echo_end_ff[gi];
         lane_done       = done_ff[gi];
         if (hit) begin
            case (item.opcode)
               OP_POLL: begin
                  case (mode_ff[gi])
                     MODE_IDLE: begin
                        if (gap_ok[gi]) begin
                           lane_pin        = 1'b1;
                           lane_trig_start = item.now_us;
                           lane_mode       = MODE_TRIG;
                        end
                     end
                     MODE_TRIG: begin
                        if ((item.now_us - trig_start_ff[gi]) >
                            {22'd0, cfg.trigger_pulse_us}) begin
                           lane_pin      = 1'b0;
                           lane_trig_end = item.now_us;
                           lane_mode     = MODE_WAIT;
                        end
                     end
                     MODE_WAIT: begin
                        if ((item.now_us - trig_end_ff[gi]) >
                            {12'd0, cfg.echo_wait_timeout_us}) begin
                           lane_pin        = 1'b1;
                           lane_trig_start = item.now_us;
                           lane_mode       = MODE_TRIG;
                        end
                     end
                     MODE_ECHO: begin
                        if (width_lane[gi] > {12'd0, cfg.echo_max_us}) begin
                           lane_pin        = 1'b1;
                           lane_trig_start = item.now_us;
                           lane_mode       = MODE_TRIG;
                        end
                     end
                     default: ;
                  endcase
               end
               OP_RISE: begin
                  if (mode_ff[gi] == MODE_WAIT) begin
                     lane_echo_start = item.now_us;
                     lane_mode       = MODE_ECHO;
                     lane_pin        = 1'b0;
                  end
               end
               OP_FALL: begin
                  if (fall_ok[gi]) begin
                     lane_done     = done_ff[gi] + 32'd1;
                     lane_echo_end = item.now_us;
                     lane_mode     = MODE_IDLE;
                     lane_pin      = 1'b0;
                  end
               end
               OP_START: begin
                  lane_mode       = MODE_IDLE;
                  lane_pin        = 1'b0;
                  lane_trig_start = 32'd0;
                  lane_trig_end   = 32'd0;
                  lane_echo_start = 32'd0;
                  lane_echo_end   = 32'd0;
                  lane_done       = 32'd0;
               end
               OP_STOP: lane_mode = MODE_STOP;
               default: ;
            endcase
         end
      end

      assign mode_in[gi]       = lane_mode;
      assign pin_in[gi]        = lane_pin;
      assign trig_start_in[gi] = lane_trig_start;
      assign trig_end_in[gi]   = lane_trig_end;
      assign echo_start_in[gi] = lane_echo_start;
      assign echo_end_in[gi]   = lane_echo_end;
      assign done_in[gi]       = lane_done;
   end

   // status of the addressed lane after the step
   always_comb begin
      result_in                = '0;
      result_in.active_channel = item.channel;
      if (is_poll || in_range) begin
         result_in.active_channel = 4'(tgt);
         for (int i = 0; i < CHANNELS; i++) begin
            if (tgt == CH_W'(i)) begin
               result_in.trigger_level = pin_in[i];
               result_in.sensor_state  = mode_code(mode_in[i]);
               result_in.frame_count   = done_in[i];
               if ((item.opcode == OP_FALL) && fall_ok[i]) begin
                  result_in.distance_valid = 1'b1;
                  result_in.echo_width_us  = width_lane[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            mode_ff[i]       <= MODE_IDLE;
            pin_ff[i]        <= 1'b0;
            trig_start_ff[i] <= 32'd0;
            trig_end_ff[i]   <= 32'd0;
            echo_start_ff[i] <= 32'd0;
            echo_end_ff[i]   <= 32'd0;
            done_ff[i]       <= 32'd0;
         end
         ptr_ff  <= '0;
         slot_ff <= 32'd0;
      end else if (take) begin
         for (int i = 0; i < CHANNELS; i++) begin
            mode_ff[i]       <= mode_in[i];
            pin_ff[i]        <= pin_in[i];
            trig_start_ff[i] <= trig_start_in[i];
            trig_end_ff[i]   <= trig_end_in[i];
            echo_start_ff[i] <= echo_start_in[i];
            echo_end_ff[i]   <= echo_end_in[i];
            done_ff[i]       <= done_in[i];
         end
         ptr_ff  <= ptr_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/msrs_scale.sv =====
// ----------------------------------------------------------------------------
// msrs_scale
// Output stage: echo width times Q0.16 scale, saturated to 16 bits, into
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msrs_scale (
   input  wire logic           clock,
   input  wire logic           load,
   input  wire logic [15:0]    scale,
   input  msrs_pkg::stage_type stage,
   output msrs_pkg::rsp_type   result
);
   import msrs_pkg::*;

   logic [47:0] prod;
   logic [31:0] scaled;
   rsp_type     result_ff, result_in;

   // width is zero when no measurement completed, so distance follows
   always_comb begin
      prod   = {16'd0, stage.echo_width_us} * {32'd0, scale};
      scaled = prod[47:16];
      result_in.active_channel = stage.active_channel;
      result_in.trigger_level  = stage.trigger_level;
      result_in.sensor_state   = stage.sensor_state;
      result_in.distance_valid = stage.distance_valid;
      result_in.echo_width_us  = stage.echo_width_us;
      result_in.frame_count    = stage.frame_count;
      result_in.distance_mm    = (|scaled[31:16]) ? 16'hFFFF : scaled[15:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== hdl/multi_sonar_ranging_sequencer.sv =====
// ----------------------------------------------------------------------------
// multi_sonar_ranging_sequencer
// Round-robin sequencer for several trigger/echo ultrasonic rangers.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one transaction: opcode (poll, echo rise, echo fall,
//    start, stop), channel and the microsecond timestamp now_us.
//  - rsp_* returns exactly one result per request: the channel touched,
//    its trigger level, state and frame count, and on a completed echo
//    the width and the distance in mm.
//  - csr_* is an APB-style register port, registers at byte address 4*i.
//    Write it only while no transaction is in flight.
//  - Three register stages: input register, channel update, distance
//    multiply/saturate. rsp_valid rises once the transaction has passed
//    the channel update and distance registers; throughput is one
//    transaction per cycle while rsp_stall is low, set by the channel
//    update loop on the state registers.
//  - Each stage holds its data while the next one is full; req_stall
//    rises only when the input register cannot move on, so empty stages
//    keep absorbing requests while rsp_stall is high.
//  - Synchronous reset returns all channels to idle, clears timers,
//    counters and the pointer, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_sonar_ranging_sequencer #(
   parameter int CHANNELS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [3:0]  req_channel,
   input  wire logic [31:0] req_now_us,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_active_channel,
   output logic             rsp_trigger_level,
   output logic [2:0]       rsp_sensor_state,
   output logic             rsp_distance_valid,
   output logic [31:0]      rsp_echo_width_us,
   output logic [15:0]      rsp_distance_mm,
   output logic [31:0]      rsp_frame_count,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import msrs_pkg::*;

   cfg_type   cfg;
   req_type   s0_ff;
   logic      s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic      s0_valid_in, s1_valid_in, s2_valid_in;
   logic      req_take, s1_take, s2_take;
   stage_type s1_data;
   rsp_type   s2_data;

   assign s2_take   = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign s1_take   = s0_valid_ff && (!s1_valid_ff || s2_take);
   assign req_stall = s0_valid_ff && !s1_take;
   assign req_take  = req_valid && !req_stall;

   assign s0_valid_in = req_take || (s0_valid_ff && !s1_take);
   assign s1_valid_in = s1_take || (s1_valid_ff && !s2_take);
   assign s2_valid_in = s2_take || (s2_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_ff.opcode  <= req_opcode;
         s0_ff.channel <= req_channel;
         s0_ff.now_us  <= req_now_us;
      end
   end

   msrs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   msrs_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (s1_take),
      .cfg    (cfg),
      .item   (s0_ff),
      .result (s1_data)
   );

   msrs_scale u_scale (
      .clock  (clock),
      .load   (s2_take),
      .scale  (cfg.mm_per_us_q16),
      .stage  (s1_data),
      .result (s2_data)
   );

   assign rsp_valid          = s2_valid_ff;
   assign rsp_active_channel = s2_data.active_channel;
   assign rsp_trigger_level  = s2_data.trigger_level;
   assign rsp_sensor_state   = s2_data.sensor_state;
   assign rsp_distance_valid = s2_data.distance_valid;
   assign rsp_echo_width_us  = s2_data.echo_width_us;
   assign rsp_distance_mm    = s2_data.distance_mm;
   assign rsp_frame_count    = s2_data.frame_count;

   // an empty input register never pushes back
   a_stall_needs_data: assert property (@(posedge clock) disable iff (reset)
      !s0_valid_ff |-> !req_stall)
      else $error("req_stall high with empty input register");

   // distance and width are only nonzero on a completed measurement
   a_dist_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_distance_valid) |->
         (rsp_distance_mm == 16'd0 && rsp_echo_width_us == 32'd0))
      else $error("distance reported without a completed measurement");

   // out-of-range channels report nothing but their index
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ({1'b0, rsp_active_channel} >= 5'(CHANNELS))) |->
         (!rsp_trigger_level && rsp_sensor_state == SC_IDLE &&
          rsp_frame_count == 32'd0 && !rsp_distance_valid))
      else $error("status reported for a channel out of range");

   // a result leaves the pipeline only after it entered the middle stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result appeared without a stage-one transaction");

endmodule

`default_nettype wire
